// ----- hdl/cpcr_pkg.sv -----
// Shared widths and constants for the circle pair collision response unit.
package cpcr_pkg;

  // Default coordinate and velocity width.
  localparam int COORD_WIDTH_DEF = 24;

  // Radius, damping register and derived arithmetic widths.
  localparam int RADIUS_W   = 16;
  localparam int DAMP_W     = 16;
  localparam int DAMP_FRAC  = 8;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd512;
  localparam int DST_W      = RADIUS_W + 1;           // sum of two radii
  localparam int SQ_W       = 2 * DST_W;              // square of a delta
  localparam int D2_W       = SQ_W + 1;               // sum of two squares
  localparam int D2_SHIFT   = 16;                     // eight extra fraction bits
  localparam int ROOT_W     = 26;                     // distance with extra bits
  localparam int RAD_W      = 2 * ROOT_W;             // radicand width
  localparam int OVQ_W      = DST_W + 8;              // overlap with extra bits
  localparam int NUMP_W     = DST_W + OVQ_W;          // delta times overlap
  localparam int NUM_W      = NUMP_W + DAMP_FRAC;     // dividend
  localparam int DEN_W      = ROOT_W + DAMP_W;        // distance times damping
  localparam int MAG_W      = OVQ_W + DAMP_FRAC;      // push magnitude, damping 1/256

endpackage

// ----- hdl/cpcr_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with side data.
module cpcr_sqrt import cpcr_pkg::*; #(
  parameter int ROOT_BITS = ROOT_W,
  parameter int SIDE_W    = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [2*ROOT_BITS-1:0]   in_rad,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [ROOT_BITS-1:0]     out_root,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int RW = 2 * ROOT_BITS;

  logic                 v_r    [ROOT_BITS];
  logic [RW-1:0]        rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] q_r    [ROOT_BITS];
  logic [SIDE_W-1:0]    side_r [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_st
    localparam int Bit = ROOT_BITS - 1 - k;
    logic                 v_in;
    logic [RW-1:0]        rem_in;
    logic [RW-1:0]        trial;
    logic [ROOT_BITS-1:0] q_in;
    logic [SIDE_W-1:0]    side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rad;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    // trial subtrahend: 2*q*2^bit + 2^(2*bit)
    assign trial = (RW'(q_in) << (Bit + 1)) | (RW'(1) << (2 * Bit));

    // advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    // settle one root bit
    always_ff @(posedge clk) begin
      side_r[k] <= side_in;
      if (rem_in >= trial) begin
        rem_r[k] <= rem_in - trial;
        q_r[k]   <= q_in | (ROOT_BITS'(1) << Bit);
      end else begin
        rem_r[k] <= rem_in;
        q_r[k]   <= q_in;
      end
    end
  end

  assign out_valid = v_r[ROOT_BITS-1];
  assign out_root  = q_r[ROOT_BITS-1];
  assign out_side  = side_r[ROOT_BITS-1];

endmodule

// ----- hdl/cpcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data.
module cpcr_div import cpcr_pkg::*; #(
  parameter int NUM_BITS = NUM_W,
  parameter int DEN_BITS = DEN_W,
  parameter int QUO_BITS = MAG_W,
  parameter int SIDE_W   = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [NUM_BITS-1:0]  in_num,
  input  logic [DEN_BITS-1:0]  in_den,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [QUO_BITS-1:0]  out_quo,
  output logic [SIDE_W-1:0]    out_side
);

  logic                v_r    [QUO_BITS];
  logic [NUM_BITS-1:0] rem_r  [QUO_BITS];
  logic [DEN_BITS-1:0] den_r  [QUO_BITS];
  logic [QUO_BITS-1:0] q_r    [QUO_BITS];
  logic [SIDE_W-1:0]   side_r [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_st
    localparam int Bit = QUO_BITS - 1 - k;
    logic                v_in;
    logic [NUM_BITS-1:0] rem_in;
    logic [DEN_BITS-1:0] den_in;
    logic [QUO_BITS-1:0] q_in;
    logic [SIDE_W-1:0]   side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    // advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    // compare the shifted remainder against the divisor and subtract
    always_ff @(posedge clk) begin
      side_r[k] <= side_in;
      den_r[k]  <= den_in;
      if ((rem_in >> Bit) >= NUM_BITS'(den_in)) begin
        rem_r[k] <= rem_in - (NUM_BITS'(den_in) << Bit);
        q_r[k]   <= q_in | (QUO_BITS'(1) << Bit);
      end else begin
        rem_r[k] <= rem_in;
        q_r[k]   <= q_in;
      end
    end
  end

  assign out_valid = v_r[QUO_BITS-1];
  assign out_quo   = q_r[QUO_BITS-1];
  assign out_side  = side_r[QUO_BITS-1];

endmodule

// ----- hdl/circle_pair_collision_response_unit.sv -----
// Throughput: one transaction per cycle; busy stays low and start is always taken.
// Depth: 4 front stages, 26 square root stages, 2 scaling stages, 33 divider
// stages and the saturating output stage, one bit of root or quotient per stage.
// Reset (synchronous, rst_n low) clears every valid bit and loads damping 2.0.
// The receiver cannot stall: each result is shown for one cycle under out_valid.
module circle_pair_collision_response_unit import cpcr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_a_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_pos_y,
  input  logic [RADIUS_W-1:0]           in_a_radius,
  input  logic signed [COORD_WIDTH-1:0] in_a_vel_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_vel_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_pos_y,
  input  logic [RADIUS_W-1:0]           in_b_radius,
  input  logic signed [COORD_WIDTH-1:0] in_b_vel_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_vel_y,
  input  logic                          in_same_particle,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_new_a_vel_x,
  output logic signed [COORD_WIDTH-1:0] out_new_a_vel_y,
  output logic signed [COORD_WIDTH-1:0] out_new_b_vel_x,
  output logic signed [COORD_WIDTH-1:0] out_new_b_vel_y,
  output logic                          out_hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [DAMP_W-1:0]             cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int CMPW = (CW + 1 > DST_W) ? CW + 1 : DST_W;
  localparam int SW   = ((CW > MAG_W) ? CW : MAG_W) + 2;
  localparam logic signed [SW-1:0] VMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = ~VMAX;

  typedef struct packed {
    logic signed [CW-1:0] avx;
    logic signed [CW-1:0] avy;
    logic signed [CW-1:0] bvx;
    logic signed [CW-1:0] bvy;
  } vel_t;

  typedef struct packed {
    vel_t             vel;
    logic             coll;
    logic             sx;
    logic             sy;
    logic [DST_W-1:0] ax;
    logic [DST_W-1:0] ay;
    logic [DST_W-1:0] dst;
  } geo_t;

  typedef struct packed {
    vel_t vel;
    logic coll;
    logic sx;
  } push_t;

  // Damping register; always ready
  logic [DAMP_W-1:0] damp_r;
  logic [DAMP_W-1:0] damp_eff;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r <= DAMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      damp_r <= cfg_data;
    end
  end

  // zero damping acts as the smallest step
  assign damp_eff = (damp_r == '0) ? DAMP_W'(1) : damp_r;

  // Stage 1: centre deltas and radius sum
  logic             s1_v_r;
  logic [CW:0]      s1_dx_r, s1_dy_r;
  logic [DST_W-1:0] s1_dst_r;
  logic             s1_same_r;
  vel_t             s1_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r   <= {in_b_pos_x[CW-1], in_b_pos_x} - {in_a_pos_x[CW-1], in_a_pos_x};
    s1_dy_r   <= {in_b_pos_y[CW-1], in_b_pos_y} - {in_a_pos_y[CW-1], in_a_pos_y};
    s1_dst_r  <= DST_W'(in_a_radius) + DST_W'(in_b_radius);
    s1_same_r <= in_same_particle;
    s1_vel_r  <= '{avx: in_a_vel_x, avy: in_a_vel_y, bvx: in_b_vel_x, bvy: in_b_vel_y};
  end

  // Stage 2: magnitudes and box reject
  logic [CW:0]      absx_full, absy_full;
  logic             s2_v_r, s2_box_r, s2_sx_r, s2_sy_r;
  logic [DST_W-1:0] s2_ax_r, s2_ay_r, s2_dst_r;
  vel_t             s2_vel_r;

  assign absx_full = s1_dx_r[CW] ? (~s1_dx_r + 1'b1) : s1_dx_r;
  assign absy_full = s1_dy_r[CW] ? (~s1_dy_r + 1'b1) : s1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_box_r <= !s1_same_r && (CMPW'(absx_full) < CMPW'(s1_dst_r))
                && (CMPW'(absy_full) < CMPW'(s1_dst_r));
    s2_sx_r  <= s1_dx_r[CW];
    s2_sy_r  <= s1_dy_r[CW];
    s2_ax_r  <= DST_W'(absx_full);
    s2_ay_r  <= DST_W'(absy_full);
    s2_dst_r <= s1_dst_r;
    s2_vel_r <= s1_vel_r;
  end

  // Stage 3: squares
  logic             s3_v_r, s3_box_r, s3_sx_r, s3_sy_r;
  logic [SQ_W-1:0]  s3_sqx_r, s3_sqy_r, s3_dst2_r;
  logic [DST_W-1:0] s3_ax_r, s3_ay_r, s3_dst_r;
  vel_t             s3_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sqx_r  <= SQ_W'(s2_ax_r) * SQ_W'(s2_ax_r);
    s3_sqy_r  <= SQ_W'(s2_ay_r) * SQ_W'(s2_ay_r);
    s3_dst2_r <= SQ_W'(s2_dst_r) * SQ_W'(s2_dst_r);
    s3_box_r  <= s2_box_r;
    s3_sx_r   <= s2_sx_r;
    s3_sy_r   <= s2_sy_r;
    s3_ax_r   <= s2_ax_r;
    s3_ay_r   <= s2_ay_r;
    s3_dst_r  <= s2_dst_r;
    s3_vel_r  <= s2_vel_r;
  end

  // Stage 4: squared distance and exact overlap test
  logic [D2_W-1:0] d2;
  logic            s4_v_r;
  logic [D2_W-1:0] s4_d2_r;
  geo_t            s4_geo_r;

  assign d2 = D2_W'(s3_sqx_r) + D2_W'(s3_sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_d2_r  <= d2;
    s4_geo_r <= '{vel: s3_vel_r,
                  coll: s3_box_r && (d2 != '0) && (d2 < D2_W'(s3_dst2_r)),
                  sx: s3_sx_r, sy: s3_sy_r,
                  ax: s3_ax_r, ay: s3_ay_r, dst: s3_dst_r};
  end

  // Distance with eight extra fraction bits
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  geo_t              sq_geo;

  cpcr_sqrt #(
    .ROOT_BITS (ROOT_W),
    .SIDE_W    ($bits(geo_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_v_r),
    .in_rad    (RAD_W'(s4_d2_r) << D2_SHIFT),
    .in_side   (s4_geo_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_geo)
  );

  // Stage 5: overlap
  logic              s5_v_r;
  logic [ROOT_W-1:0] s5_dq_r;
  logic [OVQ_W-1:0]  s5_ovq_r;
  geo_t              s5_geo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    s5_dq_r  <= sq_root;
    s5_ovq_r <= {sq_geo.dst, 8'd0} - OVQ_W'(sq_root);
    s5_geo_r <= sq_geo;
  end

  // Stage 6: dividends and divisor
  logic              s6_v_r, s6_sy_r;
  logic [NUMP_W-1:0] s6_numx_r, s6_numy_r;
  logic [DEN_W-1:0]  s6_den_r;
  push_t             s6_push_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_numx_r <= NUMP_W'(s5_geo_r.ax) * NUMP_W'(s5_ovq_r);
    s6_numy_r <= NUMP_W'(s5_geo_r.ay) * NUMP_W'(s5_ovq_r);
    s6_den_r  <= DEN_W'(s5_dq_r) * DEN_W'(damp_eff);
    s6_sy_r   <= s5_geo_r.sy;
    s6_push_r <= '{vel: s5_geo_r.vel, coll: s5_geo_r.coll, sx: s5_geo_r.sx};
  end

  // Push magnitudes on both axes
  logic             dvx_v, dvy_v, dvy_sy;
  logic [MAG_W-1:0] magx, magy;
  push_t            dv_push;

  cpcr_div #(
    .NUM_BITS (NUM_W),
    .DEN_BITS (DEN_W),
    .QUO_BITS (MAG_W),
    .SIDE_W   ($bits(push_t))
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s6_v_r),
    .in_num    (NUM_W'(s6_numx_r) << DAMP_FRAC),
    .in_den    (s6_den_r),
    .in_side   (s6_push_r),
    .out_valid (dvx_v),
    .out_quo   (magx),
    .out_side  (dv_push)
  );

  cpcr_div #(
    .NUM_BITS (NUM_W),
    .DEN_BITS (DEN_W),
    .QUO_BITS (MAG_W),
    .SIDE_W   (1)
  ) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s6_v_r),
    .in_num    (NUM_W'(s6_numy_r) << DAMP_FRAC),
    .in_den    (s6_den_r),
    .in_side   (s6_sy_r),
    .out_valid (dvy_v),
    .out_quo   (magy),
    .out_side  (dvy_sy)
  );

  // Output stage: apply equal and opposite pushes, saturate
  logic signed [SW-1:0] mx_s, my_s;
  logic signed [SW-1:0] sum_ax, sum_ay, sum_bx, sum_by;
  logic                 out_v_r, out_hit_r;
  vel_t                 out_vel_r;

  function automatic logic signed [CW-1:0] sat_v(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] res;
    if (v > VMAX) begin
      res = VMAX[CW-1:0];
    end else if (v < VMIN) begin
      res = VMIN[CW-1:0];
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  assign mx_s   = dv_push.sx ? -$signed(SW'(magx)) : $signed(SW'(magx));
  assign my_s   = dvy_sy     ? -$signed(SW'(magy)) : $signed(SW'(magy));
  assign sum_ax = SW'(dv_push.vel.avx) - mx_s;
  assign sum_ay = SW'(dv_push.vel.avy) - my_s;
  assign sum_bx = SW'(dv_push.vel.bvx) + mx_s;
  assign sum_by = SW'(dv_push.vel.bvy) + my_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= dvx_v;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= dv_push.coll;
    if (dv_push.coll) begin
      out_vel_r <= '{avx: sat_v(sum_ax), avy: sat_v(sum_ay),
                     bvx: sat_v(sum_bx), bvy: sat_v(sum_by)};
    end else begin
      out_vel_r <= dv_push.vel;
    end
  end

  assign out_valid       = out_v_r;
  assign out_hit         = out_hit_r;
  assign out_new_a_vel_x = out_vel_r.avx;
  assign out_new_a_vel_y = out_vel_r.avy;
  assign out_new_b_vel_x = out_vel_r.bvx;
  assign out_new_b_vel_y = out_vel_r.bvy;

  // Checks
  a_coll_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && s4_geo_r.coll |-> s4_d2_r != '0)
    else $error("overlap flagged with coincident centres");

  a_ovq_positive: assert property (@(posedge clk) disable iff (!rst_n)
    s5_v_r && s5_geo_r.coll |-> s5_ovq_r != '0)
    else $error("overlap flagged with no penetration");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dvx_v == dvy_v)
    else $error("axis dividers out of step");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    dvx_v |=> out_valid)
    else $error("divider result not presented");

endmodule
